### rtl/core/cpc_pkg.sv
// Shared types and constants for the contact position correction pipeline.
// No dependencies; imported by every module under rtl/core.
`default_nettype none

package cpc_pkg;

  localparam int unsigned DATA_W  = 32;
  localparam int unsigned FRAC_W  = 17;
  localparam int unsigned SLOP_W  = 31;
  localparam int unsigned SCALE_W = 33;
  localparam int unsigned CORR_W  = 49;
  localparam int unsigned SUM_W   = 33;
  localparam int unsigned DVD_W   = 49;
  localparam int unsigned QUO_W   = 17;
  localparam int unsigned WGT_W   = 17;
  localparam int unsigned CFG_AW  = 3;

  // divider stages after the entry register, minus the two multiply stages
  localparam int unsigned DLY_N = QUO_W - 2;

  localparam logic [15:0]       HALF_Q16  = 16'h8000;
  localparam logic [WGT_W-1:0]  WGT_ONE   = 17'h10000;
  localparam logic [FRAC_W-1:0] FRAC_RST  = 17'd52429;
  localparam logic [SLOP_W-1:0] SLOP_RST  = 31'd655;

  localparam logic REG_FRACTION = 1'b0;
  localparam logic REG_SLOP     = 1'b1;

  typedef enum logic [1:0] {
    KIND_RR   = 2'd0,
    KIND_RS   = 2'd1,
    KIND_SR   = 2'd2,
    KIND_SKIP = 2'd3
  } kind_t;

  typedef enum logic [1:0] {
    STAT_OK    = 2'd0,
    STAT_SKIP  = 2'd1,
    STAT_ZMASS = 2'd2
  } stat_t;

  typedef struct packed {
    logic              vld;
    stat_t             status;
    kind_t             kind;
    logic [2:0]        neg;
    logic [CORR_W-1:0] corr_x;
    logic [CORR_W-1:0] corr_y;
    logic [CORR_W-1:0] corr_z;
  } cpc_item_t;

endpackage

`default_nettype wire

### rtl/core/contact_position_correction.sv
// Contact position correction: top level with APB registers and delay line.
// Depends on cpc_pkg, cpc_front, cpc_div and cpc_back.
//
// One contact enters on any cycle with start high; busy never rises, so a
// contact can be issued every cycle. Each contact produces exactly one result
// beat on out_valid, in issue order, after it has passed through the 20
// register stages: one entry stage, 17 stages of the bit-per-stage mass-ratio
// divider, then the weighting multiply and the saturation register. The
// multiply stages run beside the divider and are aligned by a delay line.
// The receiver must take every beat in the cycle it appears. Write the
// registers only while no contact is in flight.
`default_nettype none

module contact_position_correction
  import cpc_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              start,
  output logic                   busy,
  input  wire logic [1:0]        in_pair_kind,
  input  wire logic [DATA_W-1:0] in_normal_x,
  input  wire logic [DATA_W-1:0] in_normal_y,
  input  wire logic [DATA_W-1:0] in_normal_z,
  input  wire logic [DATA_W-1:0] in_depth_in,
  input  wire logic [DATA_W-1:0] in_mass_first,
  input  wire logic [DATA_W-1:0] in_mass_second,
  output logic                   out_valid,
  output logic      [1:0]        out_status,
  output logic      [DATA_W-1:0] out_offset_first_x,
  output logic      [DATA_W-1:0] out_offset_first_y,
  output logic      [DATA_W-1:0] out_offset_first_z,
  output logic      [DATA_W-1:0] out_offset_second_x,
  output logic      [DATA_W-1:0] out_offset_second_y,
  output logic      [DATA_W-1:0] out_offset_second_z,
  input  wire logic              psel,
  input  wire logic              penable,
  input  wire logic              pwrite,
  input  wire logic [CFG_AW-1:0] paddr,
  input  wire logic [31:0]       pwdata,
  output logic      [31:0]       prdata,
  output logic                   pready
);

  logic [FRAC_W-1:0] frac_r;
  logic [SLOP_W-1:0] slop_r;
  logic              wr;
  logic              acc;

  assign pready = 1'b1;
  assign busy   = 1'b0;
  assign acc    = start && !busy;
  assign wr     = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      frac_r <= FRAC_RST;
      slop_r <= SLOP_RST;
    end else if (wr) begin
      unique case (paddr[2])
        REG_FRACTION: frac_r <= pwdata[FRAC_W-1:0];
        REG_SLOP:     slop_r <= pwdata[SLOP_W-1:0];
        default:      ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[2])
      REG_FRACTION: prdata = {{(32-FRAC_W){1'b0}}, frac_r};
      REG_SLOP:     prdata = {{(32-SLOP_W){1'b0}}, slop_r};
      default:      prdata = '0;
    endcase
  end

  logic [DVD_W-1:0] dvd;
  logic [SUM_W-1:0] dvs;
  logic [QUO_W-1:0] quo;
  cpc_item_t        fitem;

  cpc_front u_front (
    .clk         (clk),
    .rst_n       (rst_n),
    .acc         (acc),
    .pair_kind   (in_pair_kind),
    .normal_x    (in_normal_x),
    .normal_y    (in_normal_y),
    .normal_z    (in_normal_z),
    .depth_in    (in_depth_in),
    .mass_first  (in_mass_first),
    .mass_second (in_mass_second),
    .fraction    (frac_r),
    .slop        (slop_r),
    .dvd         (dvd),
    .dvs         (dvs),
    .item        (fitem)
  );

  cpc_div u_div (
    .clk (clk),
    .dvd (dvd),
    .dvs (dvs),
    .quo (quo)
  );

  // hold each correction beat until its quotient leaves the divider
  cpc_item_t dly_r [DLY_N];

  for (genvar i = 0; i < DLY_N; i++) begin : g_dly
    always_ff @(posedge clk) begin
      if (!rst_n) begin
        dly_r[i] <= '0;
      end else if (i == 0) begin
        dly_r[i] <= fitem;
      end else begin
        dly_r[i] <= dly_r[(i == 0) ? 0 : i-1];
      end
    end
  end

  cpc_back u_back (
    .clk          (clk),
    .rst_n        (rst_n),
    .item         (dly_r[DLY_N-1]),
    .quo          (quo),
    .out_valid    (out_valid),
    .out_status   (out_status),
    .out_first_x  (out_offset_first_x),
    .out_first_y  (out_offset_first_y),
    .out_first_z  (out_offset_first_z),
    .out_second_x (out_offset_second_x),
    .out_second_y (out_offset_second_y),
    .out_second_z (out_offset_second_z)
  );

  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    acc |-> ##20 out_valid)
    else $error("result beat missing 20 cycles after start");

  a_no_ghost: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(acc, 20))
    else $error("result beat without a matching start");

  a_zero_off: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_status != STAT_OK) |->
      (out_offset_first_x == '0 && out_offset_first_y == '0 &&
       out_offset_first_z == '0 && out_offset_second_x == '0 &&
       out_offset_second_y == '0 && out_offset_second_z == '0))
    else $error("skipped or zero-mass beat carries offsets");

  a_status: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_status == STAT_OK || out_status == STAT_SKIP ||
                   out_status == STAT_ZMASS))
    else $error("bad status code on result beat");

endmodule

`default_nettype wire

### rtl/core/cpc_front.sv
// Front end: entry register, scale multiply, per-axis correction multiply.
// Depends on cpc_pkg. Feeds the mass-ratio divider from its entry register.
`default_nettype none

module cpc_front
  import cpc_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              acc,
  input  wire logic [1:0]        pair_kind,
  input  wire logic [DATA_W-1:0] normal_x,
  input  wire logic [DATA_W-1:0] normal_y,
  input  wire logic [DATA_W-1:0] normal_z,
  input  wire logic [DATA_W-1:0] depth_in,
  input  wire logic [DATA_W-1:0] mass_first,
  input  wire logic [DATA_W-1:0] mass_second,
  input  wire logic [FRAC_W-1:0] fraction,
  input  wire logic [SLOP_W-1:0] slop,
  output logic      [DVD_W-1:0]  dvd,
  output logic      [SUM_W-1:0]  dvs,
  output cpc_item_t              item
);

  function automatic logic [DATA_W-1:0] mag32(input logic [DATA_W-1:0] v);
    return v[DATA_W-1] ? (~v + 1'b1) : v;
  endfunction

  // entry stage
  logic              vld0_r;
  stat_t             stat0_r;
  kind_t             kind0_r;
  logic [2:0]        neg0_r;
  logic [DATA_W-1:0] magx0_r, magy0_r, magz0_r;
  logic [SLOP_W-1:0] exc0_r;
  logic [DVD_W-1:0]  dvd0_r;
  logic [SUM_W-1:0]  sum0_r;

  logic [SUM_W-1:0]  sum_nxt;
  logic [32:0]       diff;
  logic [SLOP_W-1:0] exc_nxt;
  stat_t             stat_nxt;

  always_comb begin
    sum_nxt = {1'b0, mass_first} + {1'b0, mass_second};
    diff    = {depth_in[DATA_W-1], depth_in} - {2'b00, slop};
    exc_nxt = (!diff[32] && diff != '0) ? diff[SLOP_W-1:0] : '0;
    if (kind_t'(pair_kind) == KIND_SKIP) begin
      stat_nxt = STAT_SKIP;
    end else if (kind_t'(pair_kind) == KIND_RR && sum_nxt == '0) begin
      stat_nxt = STAT_ZMASS;
    end else begin
      stat_nxt = STAT_OK;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld0_r <= 1'b0;
    end else begin
      vld0_r <= acc;
    end
    stat0_r <= stat_nxt;
    kind0_r <= kind_t'(pair_kind);
    neg0_r  <= {normal_z[DATA_W-1], normal_y[DATA_W-1], normal_x[DATA_W-1]};
    magx0_r <= mag32(normal_x);
    magy0_r <= mag32(normal_y);
    magz0_r <= mag32(normal_z);
    exc0_r  <= exc_nxt;
    sum0_r  <= sum_nxt;
    // round(mass_second * 2^16 / sum): add half the divisor up front
    dvd0_r  <= {1'b0, mass_second, 16'h0000} + {17'h0, sum_nxt[SUM_W-1:1]};
  end

  assign dvd = dvd0_r;
  assign dvs = sum0_r;

  // scale stage
  logic              vld1_r;
  stat_t             stat1_r;
  kind_t             kind1_r;
  logic [2:0]        neg1_r;
  logic [DATA_W-1:0] magx1_r, magy1_r, magz1_r;
  logic [SCALE_W-1:0] scale1_r;
  logic [48:0]       sprod;

  assign sprod = {2'b00, exc0_r} * {32'h0, fraction} + {33'h0, HALF_Q16};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld1_r <= 1'b0;
    end else begin
      vld1_r <= vld0_r;
    end
    stat1_r  <= stat0_r;
    kind1_r  <= kind0_r;
    neg1_r   <= neg0_r;
    magx1_r  <= magx0_r;
    magy1_r  <= magy0_r;
    magz1_r  <= magz0_r;
    scale1_r <= sprod[48:16];
  end

  // correction stage
  logic [64:0] cx, cy, cz;
  cpc_item_t   item_r;

  assign cx = {33'h0, magx1_r} * {32'h0, scale1_r} + {49'h0, HALF_Q16};
  assign cy = {33'h0, magy1_r} * {32'h0, scale1_r} + {49'h0, HALF_Q16};
  assign cz = {33'h0, magz1_r} * {32'h0, scale1_r} + {49'h0, HALF_Q16};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      item_r.vld <= 1'b0;
    end else begin
      item_r.vld <= vld1_r;
    end
    item_r.status <= stat1_r;
    item_r.kind   <= kind1_r;
    item_r.neg    <= neg1_r;
    item_r.corr_x <= cx[64:16];
    item_r.corr_y <= cy[64:16];
    item_r.corr_z <= cz[64:16];
  end

  assign item = item_r;

endmodule

`default_nettype wire

### rtl/core/cpc_div.sv
// Pipelined restoring divider for the mass ratio, one quotient bit per stage.
// Depends on cpc_pkg. Takes one new beat per cycle.
`default_nettype none

module cpc_div
  import cpc_pkg::*;
(
  input  wire logic             clk,
  input  wire logic [DVD_W-1:0] dvd,
  input  wire logic [SUM_W-1:0] dvs,
  output logic      [QUO_W-1:0] quo
);

  logic [DVD_W-1:0] rem_r [QUO_W];
  logic [SUM_W-1:0] dvs_r [QUO_W];
  logic [QUO_W-1:0] quo_r [QUO_W];

  for (genvar k = 0; k < QUO_W; k++) begin : g_stage
    localparam int unsigned BIT = QUO_W - 1 - k;

    logic [DVD_W-1:0] rem_in;
    logic [SUM_W-1:0] dvs_in;
    logic [QUO_W-1:0] quo_in;
    logic [DVD_W:0]   shd;
    logic             ge;

    if (k == 0) begin : g_first
      assign rem_in = dvd;
      assign dvs_in = dvs;
      assign quo_in = '0;
    end else begin : g_next
      assign rem_in = rem_r[k-1];
      assign dvs_in = dvs_r[k-1];
      assign quo_in = quo_r[k-1];
    end

    assign shd = {{(DVD_W + 1 - SUM_W){1'b0}}, dvs_in} << BIT;
    assign ge  = {1'b0, rem_in} >= shd;

    always_ff @(posedge clk) begin
      rem_r[k] <= ge ? (rem_in - shd[DVD_W-1:0]) : rem_in;
      dvs_r[k] <= dvs_in;
      quo_r[k] <= quo_in | ({{(QUO_W-1){1'b0}}, ge} << BIT);
    end
  end

  assign quo = quo_r[QUO_W-1];

endmodule

`default_nettype wire

### rtl/core/cpc_back.sv
// Back end: mass weighting multiply, then sign, saturation and result register.
// Depends on cpc_pkg. Takes the delayed correction beat and the divider quotient.
`default_nettype none

module cpc_back
  import cpc_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire cpc_item_t         item,
  input  wire logic [QUO_W-1:0]  quo,
  output logic                   out_valid,
  output logic      [1:0]        out_status,
  output logic      [DATA_W-1:0] out_first_x,
  output logic      [DATA_W-1:0] out_first_y,
  output logic      [DATA_W-1:0] out_first_z,
  output logic      [DATA_W-1:0] out_second_x,
  output logic      [DATA_W-1:0] out_second_y,
  output logic      [DATA_W-1:0] out_second_z
);

  function automatic logic [DATA_W-1:0] pack_sat(input logic neg,
                                                 input logic [CORR_W-1:0] m);
    logic [DATA_W-1:0] v;
    if (neg) begin
      v = (m >= {{(CORR_W-DATA_W){1'b0}}, 32'h8000_0000}) ? 32'h8000_0000
                                                           : (~m[DATA_W-1:0] + 1'b1);
    end else begin
      v = (m > {{(CORR_W-DATA_W){1'b0}}, 32'h7FFF_FFFF}) ? 32'h7FFF_FFFF
                                                          : m[DATA_W-1:0];
    end
    return v;
  endfunction

  function automatic logic [CORR_W-1:0] wmul(input logic [CORR_W-1:0] c,
                                             input logic [WGT_W-1:0] w);
    logic [64:0] p;
    p = {16'h0, c} * {48'h0, w} + {49'h0, HALF_Q16};
    return p[64:16];
  endfunction

  logic [WGT_W-1:0] ratio, wa, wb;

  always_comb begin
    ratio = (quo > WGT_ONE) ? WGT_ONE : quo;
    unique case (item.kind)
      KIND_RR: begin
        wa = ratio;
        wb = WGT_ONE - ratio;
      end
      KIND_RS: begin
        wa = WGT_ONE;
        wb = '0;
      end
      KIND_SR: begin
        wa = '0;
        wb = WGT_ONE;
      end
      default: begin
        wa = '0;
        wb = '0;
      end
    endcase
  end

  logic              vld_r;
  stat_t             stat_r;
  logic [2:0]        neg_r;
  logic [CORR_W-1:0] fax_r, fay_r, faz_r, fbx_r, fby_r, fbz_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else begin
      vld_r <= item.vld;
    end
    stat_r <= item.status;
    neg_r  <= item.neg;
    fax_r  <= wmul(item.corr_x, wa);
    fay_r  <= wmul(item.corr_y, wa);
    faz_r  <= wmul(item.corr_z, wa);
    fbx_r  <= wmul(item.corr_x, wb);
    fby_r  <= wmul(item.corr_y, wb);
    fbz_r  <= wmul(item.corr_z, wb);
  end

  logic              ovld_r;
  logic [1:0]        ostat_r;
  logic [DATA_W-1:0] o1x_r, o1y_r, o1z_r, o2x_r, o2y_r, o2z_r;
  logic              live;

  // skipped and zero-mass beats drop their offsets
  assign live = (stat_r == STAT_OK);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ovld_r <= 1'b0;
    end else begin
      ovld_r <= vld_r;
    end
    ostat_r <= stat_r;
    o1x_r <= live ? pack_sat(neg_r[0] && fax_r != '0, fax_r) : '0;
    o1y_r <= live ? pack_sat(neg_r[1] && fay_r != '0, fay_r) : '0;
    o1z_r <= live ? pack_sat(neg_r[2] && faz_r != '0, faz_r) : '0;
    o2x_r <= live ? pack_sat(!neg_r[0] && fbx_r != '0, fbx_r) : '0;
    o2y_r <= live ? pack_sat(!neg_r[1] && fby_r != '0, fby_r) : '0;
    o2z_r <= live ? pack_sat(!neg_r[2] && fbz_r != '0, fbz_r) : '0;
  end

  assign out_valid    = ovld_r;
  assign out_status   = ostat_r;
  assign out_first_x  = o1x_r;
  assign out_first_y  = o1y_r;
  assign out_first_z  = o1z_r;
  assign out_second_x = o2x_r;
  assign out_second_y = o2y_r;
  assign out_second_z = o2z_r;

endmodule

`default_nettype wire
